/* hdl/clns_pkg.sv */
// shared types, codes and microcode table for the lcd nibble sequencer
`default_nettype none
package clns_pkg;

    localparam int PC_W = 6;

    localparam logic [15:0] PULSE_HOLD_RESET   = 16'd200;
    localparam logic [19:0] POWERUP_WAIT_RESET = 20'd100000;

    typedef enum logic [2:0] {
        OP_WRITE_DATA = 3'd0,
        OP_WRITE_CMD  = 3'd1,
        OP_SET_CURSOR = 3'd2,
        OP_CLEAR      = 3'd3,
        OP_INIT       = 3'd4
    } t_op;

    typedef enum logic {
        CFG_PULSE_HOLD   = 1'b0,
        CFG_POWERUP_WAIT = 1'b1
    } t_cfg_index;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    typedef enum logic [1:0] {
        NIB_HI,
        NIB_LO,
        NIB_CONST
    } t_nib_sel;

    // one control word per emitted pin state
    typedef struct packed {
        t_nib_sel    nib_sel;
        logic [3:0]  nib_const;
        logic        rs_var;
        logic        en;
        logic        hold_wait;
        logic        last;
    } t_uword;

    typedef struct packed {
        logic            ok;
        logic [PC_W-1:0] pc;
    } t_entry;

    localparam logic [PC_W-1:0] ENTRY_BYTE  = 6'd0;
    localparam logic [PC_W-1:0] ENTRY_CLEAR = 6'd6;
    localparam logic [PC_W-1:0] ENTRY_INIT  = 6'd18;

    function automatic t_uword uw_var(input logic hi, input logic en, input logic last);
        t_uword w;
        w.nib_sel   = hi ? NIB_HI : NIB_LO;
        w.nib_const = 4'h0;
        w.rs_var    = 1'b1;
        w.en        = en;
        w.hold_wait = 1'b0;
        w.last      = last;
        return w;
    endfunction

    function automatic t_uword uw_const(input logic [3:0] nib, input logic en,
                                        input logic last);
        t_uword w;
        w.nib_sel   = NIB_CONST;
        w.nib_const = nib;
        w.rs_var    = 1'b0;
        w.en        = en;
        w.hold_wait = 1'b0;
        w.last      = last;
        return w;
    endfunction

    function automatic t_uword uw_wait();
        t_uword w;
        w.nib_sel   = NIB_CONST;
        w.nib_const = 4'h0;
        w.rs_var    = 1'b0;
        w.en        = 1'b0;
        w.hold_wait = 1'b1;
        w.last      = 1'b0;
        return w;
    endfunction

    // microcode: latched byte, clear (0x01 0x02), init (wait, 2, 0x28 0x0e 0x06)
    function automatic t_uword f_rom(input logic [PC_W-1:0] pc);
        t_uword w;
        case (pc)
            6'd0, 6'd2:                     w = uw_var(1'b1, 1'b0, 1'b0);
            6'd1:                           w = uw_var(1'b1, 1'b1, 1'b0);
            6'd3:                           w = uw_var(1'b0, 1'b0, 1'b0);
            6'd4:                           w = uw_var(1'b0, 1'b1, 1'b0);
            6'd5:                           w = uw_var(1'b0, 1'b0, 1'b1);
            6'd6, 6'd8, 6'd12, 6'd14,
            6'd28, 6'd30, 6'd34, 6'd36:     w = uw_const(4'h0, 1'b0, 1'b0);
            6'd7, 6'd13, 6'd29, 6'd35:      w = uw_const(4'h0, 1'b1, 1'b0);
            6'd9, 6'd11:                    w = uw_const(4'h1, 1'b0, 1'b0);
            6'd10:                          w = uw_const(4'h1, 1'b1, 1'b0);
            6'd15, 6'd19, 6'd21,
            6'd22, 6'd24:                   w = uw_const(4'h2, 1'b0, 1'b0);
            6'd16, 6'd20, 6'd23:            w = uw_const(4'h2, 1'b1, 1'b0);
            6'd17:                          w = uw_const(4'h2, 1'b0, 1'b1);
            6'd18:                          w = uw_wait();
            6'd25, 6'd27:                   w = uw_const(4'h8, 1'b0, 1'b0);
            6'd26:                          w = uw_const(4'h8, 1'b1, 1'b0);
            6'd31, 6'd33:                   w = uw_const(4'hE, 1'b0, 1'b0);
            6'd32:                          w = uw_const(4'hE, 1'b1, 1'b0);
            6'd37:                          w = uw_const(4'h6, 1'b0, 1'b0);
            6'd38:                          w = uw_const(4'h6, 1'b1, 1'b0);
            6'd39:                          w = uw_const(4'h6, 1'b0, 1'b1);
            default:                        w = uw_const(4'h0, 1'b0, 1'b1);
        endcase
        return w;
    endfunction

    function automatic t_entry f_entry(input logic [2:0] op);
        t_entry e;
        e.ok = 1'b1;
        case (op)
            OP_WRITE_DATA, OP_WRITE_CMD, OP_SET_CURSOR: e.pc = ENTRY_BYTE;
            OP_CLEAR:                                   e.pc = ENTRY_CLEAR;
            OP_INIT:                                    e.pc = ENTRY_INIT;
            default: begin
                e.ok = 1'b0;
                e.pc = ENTRY_BYTE;
            end
        endcase
        return e;
    endfunction

endpackage
`default_nettype wire

/* hdl/char_lcd_nibble_sequencer_top.sv */
// top level: microcoded 4-bit character lcd write sequencer
//
// Each accepted request is turned into a list of pin states (nibble, rs,
// enable, hold cycles, last), one result item per pin state. A microcode
// table drives the sequencer, which emits one pin state per clock when the
// output side is ready: a data, command or cursor request gives 6 items,
// clear gives 12 and initialise gives 22. A new request is taken in the
// cycle after the last control word of the previous one has been loaded
// into the output register; unknown operation codes are accepted and
// produce nothing. The output register also lets the final item wait
// while the next request is taken. Configuration writes are meant for
// idle periods only.
`default_nettype none
module char_lcd_nibble_sequencer_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [2:0]  i_operation,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_row,
    input  wire logic [5:0]  i_column,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [3:0]       o_data_nibble,
    output logic             o_register_select,
    output logic             o_enable,
    output logic [19:0]      o_hold_cycles,
    output logic             o_last,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [19:0] i_cfg_data
);

    clns_pkg::t_state                r_state, n_state;
    logic [clns_pkg::PC_W-1:0]       r_pc;
    logic [7:0]                      r_byte;
    logic                            r_rs;
    logic [15:0]                     r_pulse_hold;
    logic [19:0]                     r_powerup_wait;
    logic                            r_out_valid;
    logic [3:0]                      r_nib;
    logic                            r_out_rs;
    logic                            r_out_en;
    logic [19:0]                     r_out_hold;
    logic                            r_out_last;

    clns_pkg::t_uword                uw;
    clns_pkg::t_entry                entry;
    logic                            in_fire;
    logic                            step;
    logic                            out_free;

    assign uw       = clns_pkg::f_rom(r_pc);
    assign entry    = clns_pkg::f_entry(i_operation);
    assign out_free = !r_out_valid || i_out_ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            clns_pkg::ST_IDLE: begin
                if (in_fire && entry.ok) n_state = clns_pkg::ST_RUN;
            end
            clns_pkg::ST_RUN: begin
                if (step && uw.last) n_state = clns_pkg::ST_IDLE;
            end
            default: n_state = clns_pkg::ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_in_ready = 1'b0;
        step       = 1'b0;
        case (r_state)
            clns_pkg::ST_IDLE: o_in_ready = 1'b1;
            clns_pkg::ST_RUN:  step       = out_free;
            default: begin
                o_in_ready = 1'b0;
                step       = 1'b0;
            end
        endcase
    end

    assign in_fire     = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= clns_pkg::ST_IDLE;
            r_pc           <= '0;
            r_out_valid    <= 1'b0;
            r_pulse_hold   <= clns_pkg::PULSE_HOLD_RESET;
            r_powerup_wait <= clns_pkg::POWERUP_WAIT_RESET;
        end else begin
            r_state <= n_state;
            if (in_fire) begin
                r_pc <= entry.pc;
            end else if (step) begin
                r_pc <= r_pc + 1'b1;
            end
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    clns_pkg::CFG_PULSE_HOLD:   r_pulse_hold   <= i_cfg_data[15:0];
                    clns_pkg::CFG_POWERUP_WAIT: r_powerup_wait <= i_cfg_data;
                    default:                    r_pulse_hold   <= r_pulse_hold;
                endcase
            end
        end
    end

    // request latch and output register
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_rs <= (i_operation == clns_pkg::OP_WRITE_DATA);
            if (i_operation == clns_pkg::OP_SET_CURSOR) begin
                r_byte <= {1'b1, i_row, i_column};
            end else begin
                r_byte <= i_data_byte;
            end
        end
        if (step) begin
            case (uw.nib_sel)
                clns_pkg::NIB_HI: r_nib <= r_byte[7:4];
                clns_pkg::NIB_LO: r_nib <= r_byte[3:0];
                default:          r_nib <= uw.nib_const;
            endcase
            r_out_rs   <= uw.rs_var && r_rs;
            r_out_en   <= uw.en;
            r_out_hold <= uw.hold_wait ? r_powerup_wait : {4'h0, r_pulse_hold};
            r_out_last <= uw.last;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_data_nibble     = r_nib;
    assign o_register_select = r_out_rs;
    assign o_enable          = r_out_en;
    assign o_hold_cycles     = r_out_hold;
    assign o_last            = r_out_last;

endmodule
`default_nettype wire

/* hdl/clns_checker.sv */
// port-level assertions for the lcd nibble sequencer, bound to the top level
`default_nettype none
module clns_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_ready,
    input wire logic [2:0]  i_operation,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [3:0]  o_data_nibble,
    input wire logic        o_enable,
    input wire logic [19:0] o_hold_cycles,
    input wire logic        o_last
);

    // a stalled result item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_data_nibble) && $stable(o_hold_cycles)
            && $stable(o_last))
        else $error("stalled result item changed");

    // strobe high states carry the 16-bit pulse hold
    a_en_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_enable |-> o_hold_cycles[19:16] == 4'h0)
        else $error("enable state with wide hold");

    // every request ends on an enable-low state
    a_last_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last |-> !o_enable)
        else $error("last item with enable high");

    // a valid request keeps the input side busy in the next cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_operation == clns_pkg::OP_WRITE_DATA
            || i_operation == clns_pkg::OP_WRITE_CMD
            || i_operation == clns_pkg::OP_SET_CURSOR
            || i_operation == clns_pkg::OP_CLEAR
            || i_operation == clns_pkg::OP_INIT)
        |=> !o_in_ready)
        else $error("input taken while sequence running");

endmodule

bind char_lcd_nibble_sequencer_top clns_checker u_clns_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .i_operation   (i_operation),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_data_nibble (o_data_nibble),
    .o_enable      (o_enable),
    .o_hold_cycles (o_hold_cycles),
    .o_last        (o_last)
);
`default_nettype wire

/* tb/tb_char_lcd_nibble_sequencer_top.sv */
// self-checking testbench for the 4-bit character lcd nibble sequencer
module tb_char_lcd_nibble_sequencer_top;

    localparam int LIMIT_CYCLES   = 200000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int IDLE_PCT       = 36;

    localparam logic [2:0] OP_UNDEF_LO = 3'd5;
    localparam logic [2:0] OP_UNDEF_HI = 3'd7;

    localparam logic [7:0] CMD_CLEAR_DISPLAY = 8'h01;
    localparam logic [7:0] CMD_RETURN_HOME   = 8'h02;
    localparam logic [7:0] CMD_FUNCTION_SET  = 8'h28;
    localparam logic [7:0] CMD_DISPLAY_ON    = 8'h0E;
    localparam logic [7:0] CMD_ENTRY_MODE    = 8'h06;
    localparam logic [7:0] CMD_SET_DDRAM     = 8'h80;
    localparam logic [7:0] DDRAM_ROW1        = 8'h40;
    localparam logic [3:0] INIT_NIBBLE       = 4'h2;

    typedef struct packed {
        logic [3:0]  nibble;
        logic        rs;
        logic        en;
        logic [19:0] hold;
        logic        last;
    } t_pin_state;

    class lcd_pin_scoreboard;
        logic [15:0] pulse_hold;
        logic [19:0] powerup_wait;
        t_pin_state  expected_pins[$];
        t_pin_state  request_pins[$];
        int          errors;

        function new();
            pulse_hold   = clns_pkg::PULSE_HOLD_RESET;
            powerup_wait = clns_pkg::POWERUP_WAIT_RESET;
            errors       = 0;
        endfunction

        function void write_register(clns_pkg::t_cfg_index idx, logic [19:0] value);
            if (idx == clns_pkg::CFG_PULSE_HOLD) begin
                pulse_hold = value[15:0];
            end else begin
                powerup_wait = value;
            end
        endfunction

        function void add_pin(logic [3:0] nib, logic rs, logic en, logic [19:0] hold);
            t_pin_state p;
            p.nibble = nib;
            p.rs     = rs;
            p.en     = en;
            p.hold   = hold;
            p.last   = 1'b0;
            request_pins.push_back(p);
        endfunction

        // enable low, high, low with the same nibble
        function void strobe(logic [3:0] nib, logic rs);
            add_pin(nib, rs, 1'b0, {4'h0, pulse_hold});
            add_pin(nib, rs, 1'b1, {4'h0, pulse_hold});
            add_pin(nib, rs, 1'b0, {4'h0, pulse_hold});
        endfunction

        function void send_byte(logic [7:0] value, logic rs);
            strobe(value[7:4], rs);
            strobe(value[3:0], rs);
        endfunction

        function void note_request(logic [2:0] op, logic [7:0] data_val, logic row_val,
                                   logic [5:0] col_val);
            t_pin_state p;
            request_pins.delete();
            case (op)
                clns_pkg::OP_WRITE_DATA: send_byte(data_val, 1'b1);
                clns_pkg::OP_WRITE_CMD:  send_byte(data_val, 1'b0);
                clns_pkg::OP_SET_CURSOR: send_byte(CMD_SET_DDRAM |
                                                   (row_val ? DDRAM_ROW1 : 8'h00) |
                                                   {2'b00, col_val}, 1'b0);
                clns_pkg::OP_CLEAR: begin
                    send_byte(CMD_CLEAR_DISPLAY, 1'b0);
                    send_byte(CMD_RETURN_HOME, 1'b0);
                end
                clns_pkg::OP_INIT: begin
                    add_pin(4'h0, 1'b0, 1'b0, powerup_wait);
                    strobe(INIT_NIBBLE, 1'b0);
                    send_byte(CMD_FUNCTION_SET, 1'b0);
                    send_byte(CMD_DISPLAY_ON, 1'b0);
                    send_byte(CMD_ENTRY_MODE, 1'b0);
                end
                default: ; // unknown codes produce nothing
            endcase
            if (request_pins.size() != 0) begin
                p = request_pins.pop_back();
                p.last = 1'b1;
                request_pins.push_back(p);
            end
            foreach (request_pins[i]) expected_pins.push_back(request_pins[i]);
        endfunction

        function void check_pin_state(t_pin_state got);
            t_pin_state want;
            if (expected_pins.size() == 0) begin
                $error("unexpected pin state: nibble %0h rs %0b en %0b hold %0d last %0b",
                       got.nibble, got.rs, got.en, got.hold, got.last);
                errors++;
                return;
            end
            want = expected_pins.pop_front();
            if (got.nibble != want.nibble) begin
                $error("data_nibble: expected %0h, got %0h", want.nibble, got.nibble);
                errors++;
            end
            if (got.rs != want.rs) begin
                $error("register_select: expected %0b, got %0b", want.rs, got.rs);
                errors++;
            end
            if (got.en != want.en) begin
                $error("enable: expected %0b, got %0b", want.en, got.en);
                errors++;
            end
            if (got.hold != want.hold) begin
                $error("hold_cycles: expected %0d, got %0d", want.hold, got.hold);
                errors++;
            end
            if (got.last != want.last) begin
                $error("last: expected %0b, got %0b", want.last, got.last);
                errors++;
            end
        endfunction

        function int outstanding();
            return expected_pins.size();
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic [2:0]            operation = '0;
    logic [7:0]            data_byte = '0;
    logic                  row       = 1'b0;
    logic [5:0]            column    = '0;
    logic                  out_ready = 1'b0;
    logic                  cfg_valid = 1'b0;
    clns_pkg::t_cfg_index  cfg_index = clns_pkg::CFG_PULSE_HOLD;
    logic [19:0]           cfg_data  = '0;
    logic                  in_ready;
    logic                  out_valid;
    logic [3:0]            data_nibble;
    logic                  register_select;
    logic                  enable;
    logic [19:0]           hold_cycles;
    logic                  last_flag;
    logic                  cfg_ready;

    bit          idling          = 1'b1;
    bit          holdoff_req     = 1'b0;
    int          holdoff_left    = 0;
    int          cycles          = 0;

    lcd_pin_scoreboard sb = new();

    char_lcd_nibble_sequencer_top u_top (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .o_in_ready        (in_ready),
        .i_operation       (operation),
        .i_data_byte       (data_byte),
        .i_row             (row),
        .i_column          (column),
        .o_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .o_data_nibble     (data_nibble),
        .o_register_select (register_select),
        .o_enable          (enable),
        .o_hold_cycles     (hold_cycles),
        .o_last            (last_flag),
        .i_cfg_valid       (cfg_valid),
        .o_cfg_ready       (cfg_ready),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // output side: random stalls, plus a long hold-off on request
    initial begin
        forever begin
            @(posedge clk);
            if (holdoff_req) begin
                holdoff_left = HOLDOFF_CYCLES;
                holdoff_req  = 1'b0;
            end
            if (holdoff_left > 0) begin
                holdoff_left--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= !(idling && $urandom_range(99) < IDLE_PCT);
            end
        end
    end

    // outputs are stable between negedge and the next posedge
    initial begin
        forever begin
            @(negedge clk);
            if (rst_n && out_valid && out_ready)
                sb.check_pin_state({data_nibble, register_select, enable, hold_cycles,
                                    last_flag});
        end
    end

    initial begin
        while (cycles < LIMIT_CYCLES) begin
            @(posedge clk);
            cycles++;
        end
        $display("tb: failure");
        $finish;
    end

    task automatic send_request(logic [2:0] op, logic [7:0] data_val, logic row_val,
                                logic [5:0] col_val);
        int gap;
        gap = 0;
        while (idling && gap < 12 && $urandom_range(99) < IDLE_PCT) gap++;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        data_byte <= data_val;
        row       <= row_val;
        column    <= col_val;
        do @(negedge clk); while (!in_ready);
        sb.note_request(op, data_val, row_val, col_val);
        @(posedge clk);
    endtask

    task automatic random_burst(int n);
        int         done;
        logic [2:0] op;
        done = 0;
        while (done < n) begin
            if ($urandom_range(99) < 8)
                op = 3'($urandom_range(OP_UNDEF_HI, OP_UNDEF_LO));
            else
                op = 3'($urandom_range(clns_pkg::OP_INIT, clns_pkg::OP_WRITE_DATA));
            send_request(op, 8'($urandom), 1'($urandom), 6'($urandom));
            done++;
        end
    endtask

    // ignored requests leave nothing expected, so let the block settle after the queue drains
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (sb.outstanding() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(clns_pkg::t_cfg_index idx, logic [19:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(negedge clk); while (!cfg_ready);
        sb.write_register(idx, value);
        @(posedge clk);
    endtask

    task automatic configure(logic [19:0] hold_val, logic [19:0] wait_val);
        write_register(clns_pkg::CFG_PULSE_HOLD, hold_val);
        write_register(clns_pkg::CFG_POWERUP_WAIT, wait_val);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed items with the reset register values
        send_request(clns_pkg::OP_WRITE_DATA, 8'h00, 1'b1, 6'h3F);
        send_request(clns_pkg::OP_WRITE_DATA, 8'hFF, 1'b0, 6'h00);
        send_request(clns_pkg::OP_WRITE_CMD, 8'hA5, 1'b1, 6'h2A);
        send_request(clns_pkg::OP_WRITE_CMD, 8'h5A, 1'b0, 6'h15);
        send_request(clns_pkg::OP_SET_CURSOR, 8'hFF, 1'b0, 6'h00);
        send_request(clns_pkg::OP_SET_CURSOR, 8'h00, 1'b1, 6'h3F);
        send_request(clns_pkg::OP_SET_CURSOR, 8'h3C, 1'b1, 6'h15);
        send_request(clns_pkg::OP_SET_CURSOR, 8'hC3, 1'b0, 6'h2A);
        send_request(clns_pkg::OP_CLEAR, 8'hFF, 1'b1, 6'h3F);
        send_request(clns_pkg::OP_INIT, 8'hFF, 1'b1, 6'h3F);
        send_request(OP_UNDEF_LO, 8'hFF, 1'b1, 6'h3F);
        send_request(OP_UNDEF_LO + 3'd1, 8'h00, 1'b0, 6'h00);
        send_request(OP_UNDEF_HI, 8'h81, 1'b1, 6'h21);
        send_request(clns_pkg::OP_WRITE_DATA, 8'h3C, 1'b0, 6'h00);
        send_request(clns_pkg::OP_INIT, 8'h00, 1'b0, 6'h00);
        wait_idle();

        configure(20'h0FFFF, 20'hFFFFF);
        random_burst(40);
        wait_idle();

        idling = 1'b0;
        configure(20'h00001, 20'h00001);
        random_burst(40);
        wait_idle();
        idling = 1'b1;

        // zero holds; upper bits of the pulse hold write are dropped
        configure(20'hF0000, 20'h00000);
        holdoff_req = 1'b1;
        random_burst(40);
        wait_idle();

        repeat (3) begin
            configure(20'($urandom), 20'($urandom));
            random_burst(32);
            wait_idle();
        end

        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
